@@ hdl/dlr_pkg.sv @@
// ----------------------------------------------------------------------------
// dlr_pkg - shared definitions for the depth line rasterizer
// Field widths, request codes, step directions and the divider status.
// ----------------------------------------------------------------------------
package dlr_pkg;

  localparam int PIX_W       = 16;
  localparam int DEPTH_W     = 32;
  localparam int COLOUR_W    = 24;
  localparam int COORD_W_DEF = 16;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic signed [1:0] DIR_NEG  = -2'sd1;
  localparam logic signed [1:0] DIR_ZERO = 2'sd0;
  localparam logic signed [1:0] DIR_POS  = 2'sd1;

  typedef struct packed {
    logic busy;
    logic done;
  } dlr_div_stat_t;

endpackage

@@ hdl/dlr_req_if.sv @@
// ----------------------------------------------------------------------------
// dlr_req_if - request channel of the rasterizer
// Start or step requests with the line endpoints, depths and colour.
// ----------------------------------------------------------------------------
interface dlr_req_if import dlr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic signed [PIX_W-1:0]    start_x;
  logic signed [PIX_W-1:0]    start_y;
  logic signed [PIX_W-1:0]    end_x;
  logic signed [PIX_W-1:0]    end_y;
  logic signed [DEPTH_W-1:0]  start_depth;
  logic signed [DEPTH_W-1:0]  end_depth;
  logic        [COLOUR_W-1:0] line_colour;

  modport source (output valid, operation, start_x, start_y, end_x, end_y,
                  start_depth, end_depth, line_colour, input ready);
  modport sink   (input valid, operation, start_x, start_y, end_x, end_y,
                  start_depth, end_depth, line_colour, output ready);
endinterface

@@ hdl/dlr_pix_if.sv @@
// ----------------------------------------------------------------------------
// dlr_pix_if - pixel channel of the rasterizer
// One pixel per start request and per step request within a line: position, depth, colour and the last-pixel flag.
// ----------------------------------------------------------------------------
interface dlr_pix_if import dlr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [PIX_W-1:0]    pixel_x;
  logic signed [PIX_W-1:0]    pixel_y;
  logic signed [DEPTH_W-1:0]  pixel_depth;
  logic        [COLOUR_W-1:0] pixel_colour;
  logic                       last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_depth, pixel_colour,
                  last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_depth, pixel_colour,
                  last_pixel, output ready);
endinterface

@@ hdl/depth_line_rasterizer_core.sv @@
// ----------------------------------------------------------------------------
// depth_line_rasterizer_core - Bresenham line walker with depth and colour
// ----------------------------------------------------------------------------
// A start request (operation 0) loads two endpoints, two depths and a colour
// and returns the first pixel; each step request (operation 1) returns the
// next pixel along the major axis, with last_pixel set on the final one. A
// step request with no line in progress is taken and returns nothing.
// Both channels are valid/ready; a request is taken when in_req.valid and
// in_req.ready are high at a rising clock edge, a pixel likewise on out_pix.
// Streaming: a step request loads its pixel straight into the output register,
// so pixels stream one per cycle while out_pix.ready stays high; so does a start
// request whose minor axis length is zero. Otherwise the depth step comes from a
// serial divider producing one quotient bit per cycle; the first pixel appears
// once the divider is done, and in_req.ready is low meanwhile.
// The pixel sits in an output register; a new request is taken in the cycle
// that pixel is taken, so a stalled receiver holds off further requests.
// Reset (rst_n low, synchronous) clears the walk state; no line is active.
// ----------------------------------------------------------------------------
module depth_line_rasterizer_core import dlr_pkg::*; #(
  parameter int COORD_WIDTH = COORD_W_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dlr_req_if.sink   in_req,
  dlr_pix_if.source out_pix
);

  localparam int LEN_W = COORD_WIDTH + 1;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;
  localparam logic [DEPTH_W-1:0] SAT_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
  localparam logic [DEPTH_W-1:0] SAT_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};

  logic                          state_r;
  logic                          active_r;
  logic signed [COORD_WIDTH-1:0] cur_x_r, cur_y_r;
  logic signed [DEPTH_W-1:0]     cur_depth_r;
  logic        [LEN_W-1:0]       error_acc_r;
  logic        [LEN_W-1:0]       steps_left_r;
  logic        [LEN_W-1:0]       major_len_r, minor_len_r;
  logic signed [1:0]             dir_x_r, dir_y_r;
  logic                          x_is_major_r;
  logic signed [DEPTH_W-1:0]     depth_step_r;
  logic        [COLOUR_W-1:0]    held_colour_r;

  logic                          out_valid_r;
  logic signed [PIX_W-1:0]       out_x_r, out_y_r;
  logic signed [DEPTH_W-1:0]     out_depth_r;
  logic        [COLOUR_W-1:0]    out_colour_r;
  logic                          out_last_r;

  logic                          in_fire;
  logic                          div_start;
  dlr_div_stat_t                 div_stat;
  logic signed [DEPTH_W-1:0]     div_quot;

  // setup path
  logic signed [COORD_WIDTH-1:0] ax, ay, bx, by;
  logic signed [LEN_W-1:0]       dx, dy;
  logic        [LEN_W-1:0]       adx, ady, major_in, minor_in;
  logic signed [1:0]             dir_x_in, dir_y_in;
  logic                          x_major_in;
  logic signed [DEPTH_W:0]       dz;

  // step path
  logic        [LEN_W-1:0]       err_sum;
  logic                          minor_step;
  logic signed [COORD_WIDTH-1:0] x_inc, y_inc, x_next, y_next;
  logic signed [DEPTH_W:0]       depth_sum;
  logic signed [DEPTH_W-1:0]     depth_sat, depth_next;
  logic        [LEN_W-1:0]       steps_dec;

  assign ax = in_req.start_x[COORD_WIDTH-1:0];
  assign ay = in_req.start_y[COORD_WIDTH-1:0];
  assign bx = in_req.end_x[COORD_WIDTH-1:0];
  assign by = in_req.end_y[COORD_WIDTH-1:0];

  assign dx  = LEN_W'(bx) - LEN_W'(ax);
  assign dy  = LEN_W'(by) - LEN_W'(ay);
  assign adx = dx[LEN_W-1] ? -dx : dx;
  assign ady = dy[LEN_W-1] ? -dy : dy;

  assign dir_x_in = (dx == '0) ? DIR_ZERO : (dx[LEN_W-1] ? DIR_NEG : DIR_POS);
  assign dir_y_in = (dy == '0) ? DIR_ZERO : (dy[LEN_W-1] ? DIR_NEG : DIR_POS);
  assign x_major_in = adx >= ady;
  assign major_in   = x_major_in ? adx : ady;
  assign minor_in   = x_major_in ? ady : adx;
  assign dz = (DEPTH_W+1)'(in_req.end_depth) - (DEPTH_W+1)'(in_req.start_depth);

  // The error stays below the major length, so the sum cannot overflow.
  assign err_sum    = error_acc_r + minor_len_r;
  assign minor_step = err_sum >= major_len_r;
  assign x_inc = cur_x_r + COORD_WIDTH'(dir_x_r);
  assign y_inc = cur_y_r + COORD_WIDTH'(dir_y_r);
  assign x_next = (x_is_major_r || minor_step) ? x_inc : cur_x_r;
  assign y_next = (!x_is_major_r || minor_step) ? y_inc : cur_y_r;

  assign depth_sum = (DEPTH_W+1)'(cur_depth_r) + (DEPTH_W+1)'(depth_step_r);
  assign depth_sat = (depth_sum[DEPTH_W] != depth_sum[DEPTH_W-1])
                     ? (depth_sum[DEPTH_W] ? SAT_MIN : SAT_MAX)
                     : depth_sum[DEPTH_W-1:0];
  assign depth_next = minor_step ? depth_sat : cur_depth_r;
  assign steps_dec  = steps_left_r - LEN_W'(1);

  assign in_req.ready = (state_r == ST_IDLE) && (!out_valid_r || out_pix.ready);
  assign in_fire      = in_req.valid && in_req.ready;
  assign div_start    = in_fire && (in_req.operation == OP_START) && (minor_in != '0);

  dlr_div #(.DIVISOR_W(LEN_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dz),
    .divisor  (minor_in),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      active_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      cur_depth_r   <= '0;
      error_acc_r   <= '0;
      steps_left_r  <= '0;
      major_len_r   <= '0;
      minor_len_r   <= '0;
      dir_x_r       <= DIR_ZERO;
      dir_y_r       <= DIR_ZERO;
      x_is_major_r  <= 1'b0;
      depth_step_r  <= '0;
      held_colour_r <= '0;
    end else begin
      if (out_valid_r && out_pix.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire && (in_req.operation == OP_START)) begin
            cur_x_r       <= ax;
            cur_y_r       <= ay;
            cur_depth_r   <= in_req.start_depth;
            error_acc_r   <= major_in >> 1;
            steps_left_r  <= major_in;
            major_len_r   <= major_in;
            minor_len_r   <= minor_in;
            dir_x_r       <= dir_x_in;
            dir_y_r       <= dir_y_in;
            x_is_major_r  <= x_major_in;
            held_colour_r <= in_req.line_colour;
            active_r      <= (major_in != '0);
            out_x_r       <= PIX_W'(ax);
            out_y_r       <= PIX_W'(ay);
            out_depth_r   <= in_req.start_depth;
            out_colour_r  <= in_req.line_colour;
            out_last_r    <= (major_in == '0);
            if (minor_in == '0) begin
              depth_step_r <= '0;
              out_valid_r  <= 1'b1;
            end else begin
              state_r <= ST_DIV;
            end
          end else if (in_fire && (in_req.operation == OP_STEP) && active_r) begin
            error_acc_r  <= minor_step ? err_sum - major_len_r : err_sum;
            cur_x_r      <= x_next;
            cur_y_r      <= y_next;
            cur_depth_r  <= depth_next;
            steps_left_r <= steps_dec;
            active_r     <= (steps_dec != '0);
            out_x_r      <= PIX_W'(x_next);
            out_y_r      <= PIX_W'(y_next);
            out_depth_r  <= depth_next;
            out_colour_r <= held_colour_r;
            out_last_r   <= (steps_dec == '0);
            out_valid_r  <= 1'b1;
          end
        end
        ST_DIV: begin
          // hold until the depth step is known, then release the first pixel
          if (div_stat.done) begin
            depth_step_r <= div_quot;
            out_valid_r  <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_pix.valid        = out_valid_r;
  assign out_pix.pixel_x      = out_x_r;
  assign out_pix.pixel_y      = out_y_r;
  assign out_pix.pixel_depth  = out_depth_r;
  assign out_pix.pixel_colour = out_colour_r;
  assign out_pix.last_pixel   = out_last_r;

  a_busy_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> !in_req.ready)
    else $error("request taken while the divider runs");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  a_no_pixel_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !out_valid_r)
    else $error("pixel pending while the depth step is computed");

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> !active_r)
    else $error("last pixel flagged while the line is still active");

endmodule

@@ hdl/dlr_div.sv @@
// ----------------------------------------------------------------------------
// dlr_div - serial depth step divider
// Signed depth delta over unsigned minor length, one quotient bit per cycle,
// truncated toward zero and saturated to the signed depth range.
// ----------------------------------------------------------------------------
module dlr_div import dlr_pkg::*; #(
  parameter int DIVISOR_W = COORD_W_DEF + 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [DEPTH_W:0]    dividend,
  input  logic        [DIVISOR_W-1:0] divisor,
  output dlr_div_stat_t              stat,
  output logic signed [DEPTH_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(DEPTH_W + 1);
  localparam logic [DEPTH_W-1:0] SAT_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
  localparam logic [DEPTH_W-1:0] SAT_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};

  logic [CNT_W-1:0]     cnt_r;
  logic                 done_r;
  logic                 neg_r;
  logic [DEPTH_W-1:0]   mag_r;
  logic [DIVISOR_W-1:0] rem_r;
  logic [DIVISOR_W-1:0] dvs_r;

  logic signed [DEPTH_W:0] dividend_neg;
  logic [DEPTH_W-1:0]      dividend_mag;
  logic [DIVISOR_W:0]      trial;
  logic [DIVISOR_W:0]      diff;
  logic                    qbit;

  assign dividend_neg = -dividend;
  assign dividend_mag = dividend[DEPTH_W] ? dividend_neg[DEPTH_W-1:0]
                                          : dividend[DEPTH_W-1:0];

  assign trial = {rem_r, mag_r[DEPTH_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign qbit  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (start) begin
        cnt_r <= CNT_W'(DEPTH_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // Quotient bits shift in as dividend bits shift out.
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[DEPTH_W];
      mag_r <= dividend_mag;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      mag_r <= {mag_r[DEPTH_W-2:0], qbit};
      rem_r <= qbit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  always_comb begin
    if (neg_r) begin
      quotient = mag_r[DEPTH_W-1] ? SAT_MIN : -mag_r;
    end else begin
      quotient = mag_r[DEPTH_W-1] ? SAT_MAX : mag_r;
    end
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> $past(cnt_r) == CNT_W'(1))
    else $error("divider done without a final iteration");

  a_busy_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> cnt_r == CNT_W'(DEPTH_W))
    else $error("divider did not load its iteration count");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |=> !stat.done || $past(start, 2))
    else $error("divider done held over two cycles");

endmodule
